### rtl/pfb_pkg.sv
// ----------------------------------------------------------------------------
// pfb_pkg: shared definitions for the page framebuffer blit engine
// Request codes, field widths and fixed limits used by the engine and by
// its port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package pfb_pkg;

    // Field widths of one request beat and one result beat.
    localparam int REQ_W   = 3;
    localparam int POS_X_W = 9;
    localparam int POS_Y_W = 8;
    localparam int SIZE_W_W = 8;
    localparam int SIZE_H_W = 7;
    localparam int BYTE_W  = 8;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_FILL     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PIXEL    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_IMG_BEGIN = 3'd2;
    localparam logic [REQ_W-1:0] REQ_IMG_BYTE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ     = 3'd4;

    // Page count of one image saturates here.
    localparam logic [3:0] IMG_PAGES_MAX = 4'd15;

endpackage : pfb_pkg

`default_nettype wire

### rtl/page_framebuffer_blit_engine.sv
// ----------------------------------------------------------------------------
// page_framebuffer_blit_engine: page-organized monochrome frame store
// Holds PAGES x COLUMNS bytes (8 vertical pixels per byte, bit 0 on top)
// in one synchronous RAM and applies draw requests by read-modify-write.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: i_valid / o_stall with the fields i_req_type, i_pos_x,
//   i_pos_y, i_size_w, i_size_h and i_data_byte. A beat is taken at a rising
//   edge with i_valid high and o_stall low. One request is worked at a time.
//   Result channel: o_valid / i_stall with o_read_data. Only a read request
//   gives a result beat; it is held in an output register, so new requests
//   are taken while it waits for the receiver.
//   Steps per request, set by the single RAM port pair and the
//   read-modify-write sequence:
//     begin image, unknown code, ignored image byte, or a pixel or image
//       byte that falls wholly off the screen: taken without a stall
//     set pixel, image byte that writes one on-screen page: one read, one write
//     image byte that writes two on-screen pages: a read and a write per page
//     read byte: a RAM lookup, then a wait to load the result register
//       while the receiver stalls a previous result
//     fill: a sweep over all PAGES*COLUMNS entries, one RAM entry written per cycle
//   Reset: i_rst_n (synchronous, active low) clears the image state and
//   starts a clearing pass over all PAGES*COLUMNS entries (1024 by default)
//   that writes zero to each; o_stall stays high until it is done.
// ----------------------------------------------------------------------------
`default_nettype none

module page_framebuffer_blit_engine
    import pfb_pkg::*;
#(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // request channel
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [REQ_W-1:0]           i_req_type,
    input  wire logic signed [POS_X_W-1:0]  i_pos_x,
    input  wire logic signed [POS_Y_W-1:0]  i_pos_y,
    input  wire logic [SIZE_W_W-1:0]        i_size_w,
    input  wire logic [SIZE_H_W-1:0]        i_size_h,
    input  wire logic [BYTE_W-1:0]          i_data_byte,
    // result channel
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [BYTE_W-1:0]               o_read_data
);

    localparam int DEPTH = PAGES * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    // Sequencer state codes.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SWEEP = 3'd1;
    localparam logic [2:0] ST_RD0   = 3'd2;
    localparam logic [2:0] ST_WR0   = 3'd3;
    localparam logic [2:0] ST_RD1   = 3'd4;
    localparam logic [2:0] ST_WR1   = 3'd5;
    localparam logic [2:0] ST_LOOK  = 3'd6;
    localparam logic [2:0] ST_RESP  = 3'd7;

    // Linear RAM address of an on-screen page and column.
    function automatic logic [AW-1:0] f_addr(input logic signed [5:0] pg,
                                             input logic signed [10:0] cl);
        return AW'(int'(pg) * COLUMNS + int'(cl));
    endfunction

    // True when a page and column fall inside the screen.
    function automatic logic f_on(input logic signed [5:0] pg,
                                  input logic signed [10:0] cl);
        return (pg >= 0) && (int'(pg) < PAGES) && (cl >= 0) && (int'(cl) < COLUMNS);
    endfunction

    // Control registers.
    logic [2:0]            r_state, n_state;
    logic [AW-1:0]         r_cnt;
    logic [BYTE_W-1:0]     r_fill;
    logic                  r_out_valid;

    // Image state.
    logic signed [POS_X_W-1:0] r_org_x;
    logic signed [POS_Y_W-1:0] r_org_y;
    logic [SIZE_W_W-1:0]   r_img_w;
    logic [3:0]            r_img_pages;
    logic [7:0]            r_col_cnt;
    logic [3:0]            r_page_cnt;

    // Pending accesses of the current request.
    logic [AW-1:0]         r_addr0, r_addr1;
    logic [BYTE_W-1:0]     r_bits0, r_bits1;
    logic                  r_en0, r_en1;
    logic [BYTE_W-1:0]     r_read_data;

    // RAM and its port controls.
    logic [BYTE_W-1:0]     mem [DEPTH];
    logic [BYTE_W-1:0]     r_mem_q;
    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [BYTE_W-1:0]     mem_wdata;

    logic                  in_acc;
    logic                  out_free;

    // Address decode for set pixel and read byte.
    logic signed [5:0]     pix_pg;
    logic signed [10:0]    pix_col;
    logic                  pix_on;

    // Address decode for an image byte.
    logic signed [5:0]     img_pg, img_pg1;
    logic signed [10:0]    img_col;
    logic                  img_act, img_en0, img_en1;
    logic [15:0]           img_sh;

    // Counters after an image byte.
    logic [8:0]            n_col;
    logic [4:0]            beg_pages;

    assign in_acc   = i_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_read_data = r_read_data;

    // Floor division of the row by 8 is an arithmetic shift.
    assign pix_pg  = 6'(i_pos_y >>> 3);
    assign pix_col = 11'(i_pos_x);
    assign pix_on  = f_on(pix_pg, pix_col);

    assign img_pg  = 6'(r_org_y >>> 3) + $signed({2'b00, r_page_cnt});
    assign img_pg1 = img_pg + 6'sd1;
    assign img_col = 11'(r_org_x) + $signed({3'b000, r_col_cnt});
    assign img_sh  = {8'h00, i_data_byte} << r_org_y[2:0];
    assign img_act = (r_img_pages != 4'd0) && (r_page_cnt < r_img_pages);
    assign img_en0 = f_on(img_pg, img_col);
    assign img_en1 = (r_org_y[2:0] != 3'd0) && f_on(img_pg1, img_col);

    assign n_col = {1'b0, r_col_cnt} + 9'd1;
    assign beg_pages = 5'((i_size_h - 7'd1) >> 3) + 5'd1;

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (i_req_type)
                        REQ_FILL:  n_state = ST_SWEEP;
                        REQ_PIXEL: n_state = pix_on ? ST_RD0 : ST_IDLE;
                        REQ_IMG_BYTE: begin
                            if (!img_act) begin
                                n_state = ST_IDLE;
                            end else if (img_en0) begin
                                n_state = ST_RD0;
                            end else if (img_en1) begin
                                n_state = ST_RD1;
                            end else begin
                                n_state = ST_IDLE;
                            end
                        end
                        REQ_READ:  n_state = ST_LOOK;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SWEEP: n_state = (r_cnt == LAST_ADDR) ? ST_IDLE : ST_SWEEP;
            ST_RD0:   n_state = ST_WR0;
            ST_WR0:   n_state = r_en1 ? ST_RD1 : ST_IDLE;
            ST_RD1:   n_state = ST_WR1;
            ST_WR1:   n_state = ST_IDLE;
            ST_LOOK:  n_state = ST_RESP;
            ST_RESP:  n_state = out_free ? ST_IDLE : ST_RESP;
        endcase
    end

    // RAM port controls for each step of a request.
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_addr0;
        mem_raddr = r_addr0;
        mem_wdata = r_mem_q | r_bits0;
        unique case (r_state)
            ST_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = r_fill;
            end
            ST_RD0:  mem_re = 1'b1;
            ST_WR0:  mem_we = 1'b1;
            ST_RD1: begin
                mem_re    = 1'b1;
                mem_raddr = r_addr1;
            end
            ST_WR1: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr1;
                mem_wdata = r_mem_q | r_bits1;
            end
            ST_LOOK: mem_re = r_en0;
            default: begin
                mem_we = 1'b0;
                mem_re = 1'b0;
            end
        endcase
    end

    // Frame RAM with registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= mem[mem_raddr];
        end
    end

    // Control and image state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_cnt       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_org_x     <= '0;
            r_org_y     <= '0;
            r_img_w     <= 8'd1;
            r_img_pages <= 4'd0;
            r_col_cnt   <= 8'd0;
            r_page_cnt  <= 4'd0;
        end else begin
            r_state <= n_state;

            // The sweep counter restarts on a fill and steps while sweeping.
            if (in_acc && (i_req_type == REQ_FILL)) begin
                r_cnt  <= '0;
                r_fill <= i_data_byte;
            end else if (r_state == ST_SWEEP) begin
                r_cnt <= r_cnt + AW'(1);
            end

            // Begin image latches the origin and size.
            if (in_acc && (i_req_type == REQ_IMG_BEGIN)) begin
                r_org_x    <= i_pos_x;
                r_org_y    <= i_pos_y;
                r_img_w    <= i_size_w;
                r_col_cnt  <= 8'd0;
                r_page_cnt <= 4'd0;
                if ((i_size_w == '0) || (i_size_h == '0)) begin
                    r_img_pages <= 4'd0;
                end else if (beg_pages > 5'(IMG_PAGES_MAX)) begin
                    r_img_pages <= IMG_PAGES_MAX;
                end else begin
                    r_img_pages <= beg_pages[3:0];
                end
            end

            // Each taken image byte advances column, then page.
            if (in_acc && (i_req_type == REQ_IMG_BYTE) && img_act) begin
                if (n_col >= {1'b0, r_img_w}) begin
                    r_col_cnt  <= 8'd0;
                    r_page_cnt <= r_page_cnt + 4'd1;
                end else begin
                    r_col_cnt <= n_col[7:0];
                end
            end

            // Output register: loaded from a finished read, freed by the receiver.
            if ((r_state == ST_RESP) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Access plan of the taken request and the result byte.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (i_req_type == REQ_IMG_BYTE) begin
                r_addr0 <= f_addr(img_pg, img_col);
                r_addr1 <= f_addr(img_pg1, img_col);
                r_bits0 <= img_sh[7:0];
                r_bits1 <= img_sh[15:8];
                r_en0   <= img_en0;
                r_en1   <= img_en1;
            end else begin
                r_addr0 <= f_addr(pix_pg, pix_col);
                r_addr1 <= f_addr(pix_pg, pix_col);
                r_bits0 <= 8'h01 << i_pos_y[2:0];
                r_bits1 <= 8'h00;
                r_en0   <= pix_on;
                r_en1   <= 1'b0;
            end
        end
        if ((r_state == ST_RESP) && out_free) begin
            r_read_data <= r_en0 ? r_mem_q : 8'h00;
        end
    end

endmodule : page_framebuffer_blit_engine

`default_nettype wire

### rtl/pfb_checker.sv
// ----------------------------------------------------------------------------
// pfb_checker: port checker for the page framebuffer blit engine
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_checker
    import pfb_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_stall,
    input wire logic [REQ_W-1:0]  i_req_type,
    input wire logic              o_valid,
    input wire logic              i_stall,
    input wire logic [BYTE_W-1:0] o_read_data
);

    // A fill beat always starts a sweep that holds off new requests.
    a_fill_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_req_type == REQ_FILL)) |=> o_stall)
        else $error("fill beat taken without a sweep");

    // A read beat holds off new requests for its lookup step.
    a_read_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_req_type == REQ_READ)) |=> o_stall)
        else $error("read beat taken without a lookup cycle");

    // A new result beat comes only from a request still in work.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result beat appeared while idle");

    // A stalled result beat stays and holds its data.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_read_data)))
        else $error("stalled result beat changed");

endmodule : pfb_checker

bind page_framebuffer_blit_engine pfb_checker u_pfb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_req_type  (i_req_type),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_read_data (o_read_data)
);

`default_nettype wire

### tb/pfb_port_checker.sv
// ----------------------------------------------------------------------------
// pfb_port_checker: frame store predictor and read-back checker
// Watches the request and result channels of the blit engine, keeps its own
// copy of the frame store and image state, and compares every read beat
// with the byte that the drawing so far should have left there.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfb_port_checker
    import pfb_pkg::*;
#(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // request channel
    input  wire logic                       i_req_valid,
    input  wire logic                       i_req_stall,
    input  wire logic [REQ_W-1:0]           i_req_type,
    input  wire logic signed [POS_X_W-1:0]  i_pos_x,
    input  wire logic signed [POS_Y_W-1:0]  i_pos_y,
    input  wire logic [SIZE_W_W-1:0]        i_size_w,
    input  wire logic [SIZE_H_W-1:0]        i_size_h,
    input  wire logic [BYTE_W-1:0]          i_data_byte,
    // result channel
    input  wire logic                       i_res_valid,
    input  wire logic                       i_res_stall,
    input  wire logic [BYTE_W-1:0]          i_read_data,
    // status
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_reads_checked
);

    // Predicted frame store and image state.
    logic [BYTE_W-1:0]          frame_mem [PAGES*COLUMNS];
    logic signed [POS_X_W-1:0]  img_org_x;
    logic signed [POS_Y_W-1:0]  img_org_y;
    logic [SIZE_W_W-1:0]        img_width;
    logic [3:0]                 img_pages;
    logic [3:0]                 img_page_idx;
    logic [7:0]                 img_col_idx;

    // Bytes that the pending reads should return, oldest first.
    logic [BYTE_W-1:0]          read_expect_q [$];

    int fail_count    = 0;
    int pending_count = 0;
    int reads_checked = 0;
    logic [BYTE_W-1:0] want;

    assign o_fail_count    = fail_count;
    assign o_pending       = pending_count;
    assign o_reads_checked = reads_checked;

    function automatic bit on_screen(int page, int col);
        return page >= 0 && page < PAGES && col >= 0 && col < COLUMNS;
    endfunction

    // OR bits into one stored byte; writes off the screen are dropped.
    task automatic or_into_frame(int page, int col, logic [BYTE_W-1:0] bits);
        if (on_screen(page, col)) begin
            frame_mem[page*COLUMNS + col] |= bits;
        end
    endtask

    // Apply one accepted request to the predicted state.
    task automatic predict_draw(
        logic [REQ_W-1:0]          kind,
        logic signed [POS_X_W-1:0] x,
        logic signed [POS_Y_W-1:0] y,
        logic [SIZE_W_W-1:0]       w,
        logic [SIZE_H_W-1:0]       h,
        logic [BYTE_W-1:0]         d
    );
        int          page;
        int          col;
        int          span;
        logic [2:0]  shift;
        logic [15:0] spread;
        case (kind)
            REQ_FILL: begin
                foreach (frame_mem[i]) frame_mem[i] = d;
            end
            REQ_PIXEL: begin
                // Arithmetic shift gives the floor page for negative rows.
                page = y >>> 3;
                col  = x;
                or_into_frame(page, col, 8'h01 << y[2:0]);
            end
            REQ_IMG_BEGIN: begin
                img_org_x    = x;
                img_org_y    = y;
                img_width    = w;
                img_col_idx  = '0;
                img_page_idx = '0;
                if (w == 0 || h == 0) begin
                    img_pages = '0;
                end else begin
                    span      = (int'(h) - 1) / 8 + 1;
                    img_pages = (span > int'(IMG_PAGES_MAX)) ? IMG_PAGES_MAX : span[3:0];
                end
            end
            REQ_IMG_BYTE: begin
                // Ignored while no image is active or once it is complete.
                if (img_pages != 0 && img_page_idx < img_pages) begin
                    shift  = img_org_y[2:0];
                    page   = img_org_y >>> 3;
                    page  += img_page_idx;
                    col    = img_org_x;
                    col   += img_col_idx;
                    spread = {8'h00, d} << shift;
                    or_into_frame(page, col, spread[7:0]);
                    if (shift != 0) begin
                        or_into_frame(page + 1, col, spread[15:8]);
                    end
                    img_col_idx++;
                    if (img_col_idx >= img_width) begin
                        img_col_idx = '0;
                        img_page_idx++;
                    end
                end
            end
            REQ_READ: begin
                page = y >>> 3;
                col  = x;
                read_expect_q.push_back(on_screen(page, col) ?
                                        frame_mem[page*COLUMNS + col] : '0);
            end
            default: begin
                // Unknown request codes are dropped without a result.
            end
        endcase
    endtask

    // Result beats are checked before the request of the same edge is applied.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (frame_mem[i]) frame_mem[i] = '0;
            img_org_x    = '0;
            img_org_y    = '0;
            img_width    = 8'd1;
            img_pages    = '0;
            img_page_idx = '0;
            img_col_idx  = '0;
            read_expect_q.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (read_expect_q.size() == 0) begin
                    $error("read_data beat with no read pending: actual %02h", i_read_data);
                    fail_count++;
                end else begin
                    want = read_expect_q.pop_front();
                    reads_checked++;
                    if (i_read_data !== want) begin
                        $error("read_data mismatch: expected %02h, actual %02h",
                               want, i_read_data);
                        fail_count++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                predict_draw(i_req_type, i_pos_x, i_pos_y, i_size_w, i_size_h,
                             i_data_byte);
            end
        end
        pending_count = read_expect_q.size();
    end

endmodule : pfb_port_checker

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the page framebuffer blit engine
// Drives fills, pixels, images and reads with bursty request timing and a
// stalling result receiver, including one long hold-off; the port checker
// predicts every read-back byte and the run ends with a verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
    import pfb_pkg::*;
();

    localparam int COLUMNS      = 128;
    localparam int PAGES        = 8;
    localparam int ITEM_TARGET  = 1800;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 10000;
    localparam int DRAIN_CYCLES = 1100;

    typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_PERIODIC} t_sink_mode;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_valid     = 1'b0;
    logic                      i_stall     = 1'b0;
    logic [REQ_W-1:0]          i_req_type  = REQ_FILL;
    logic signed [POS_X_W-1:0] i_pos_x     = '0;
    logic signed [POS_Y_W-1:0] i_pos_y     = '0;
    logic [SIZE_W_W-1:0]       i_size_w    = '0;
    logic [SIZE_H_W-1:0]       i_size_h    = '0;
    logic [BYTE_W-1:0]         i_data_byte = '0;
    logic                      o_stall;
    logic                      o_valid;
    logic [BYTE_W-1:0]         o_read_data;

    int fail_count;
    int pending_reads;
    int reads_checked;

    int counted_items = 0;
    int burst_left    = 0;
    int fills_sent    = 0;
    int pixels_sent   = 0;
    int img_beats     = 0;
    int reads_sent    = 0;
    bit hold_go       = 1'b0;

    page_framebuffer_blit_engine #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req_type  (i_req_type),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_size_w    (i_size_w),
        .i_size_h    (i_size_h),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_read_data (o_read_data)
    );

    pfb_port_checker #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_port_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_stall     (o_stall),
        .i_req_type      (i_req_type),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_size_w        (i_size_w),
        .i_size_h        (i_size_h),
        .i_data_byte     (i_data_byte),
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_read_data     (o_read_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending_reads),
        .o_reads_checked (reads_checked)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Offer one request beat and return at the edge that takes it. Bursts
    // of random length are separated by random gaps; some bursts run on
    // back to back. Field values are cut to the port widths here.
    task automatic send_beat(
        logic [REQ_W-1:0] kind,
        int               x,
        int               y,
        int               w,
        int               h,
        int               d,
        bit               counted
    );
        bit took;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_req_type  <= kind;
        i_pos_x     <= POS_X_W'(x);
        i_pos_y     <= POS_Y_W'(y);
        i_size_w    <= SIZE_W_W'(w);
        i_size_h    <= SIZE_H_W'(h);
        i_data_byte <= BYTE_W'(d);
        // Stall is stable between edges, so sample it at the preceding falling edge.
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = !o_stall;
            @(posedge i_clk);
        end
        if (counted) counted_items++;
        case (kind)
            REQ_FILL:     fills_sent++;
            REQ_PIXEL:    pixels_sent++;
            REQ_IMG_BYTE: img_beats++;
            REQ_READ:     reads_sent++;
            default:      ;
        endcase
    endtask

    task automatic read_beat(int x, int y);
        send_beat(REQ_READ, x, y, $urandom, $urandom, $urandom, 1'b1);
    endtask

    // Mostly on-screen columns and rows, now and then the whole field.
    function automatic int rand_col();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                           : $urandom_range(0, COLUMNS - 1);
    endfunction

    function automatic int rand_row();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                           : $urandom_range(0, PAGES*8 - 1);
    endfunction

    // One image: begin, its bytes with reads mixed in, then reads of the
    // area. Some sequences are cut short and some carry excess bytes.
    task automatic draw_image();
        int  ox;
        int  oy;
        int  w;
        int  h;
        int  total;
        int  excess;
        bit  broken;
        w  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 12);
        if (w > 16) h = $urandom_range(1, 8);
        else h = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 20);
        ox     = int'($urandom_range(0, 145)) - 12;
        oy     = int'($urandom_range(0, 88)) - 16;
        total  = w * ((h - 1) / 8 + 1);
        broken = ($urandom_range(0, 9) == 0);
        excess = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        if (broken) total = $urandom_range(0, total - 1);
        send_beat(REQ_IMG_BEGIN, ox, oy, w, h, $urandom, 1'b1);
        for (int i = 0; i < total; i++) begin
            if ($urandom_range(0, 5) == 0) read_beat(rand_col(), rand_row());
            send_beat(REQ_IMG_BYTE, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b1);
        end
        if (!broken) begin
            for (int i = 0; i < excess; i++) begin
                send_beat(REQ_IMG_BYTE, $urandom, $urandom, $urandom, $urandom,
                          $urandom, 1'b0);
            end
        end
        repeat ($urandom_range(1, 4)) begin
            read_beat(ox + int'($urandom_range(0, w)), oy + int'($urandom_range(0, h + 8)));
        end
    endtask

    // Result receiver: changes its stall pattern every so often and holds
    // off once for a long stretch so that the engine backs up.
    initial begin : result_sink
        t_sink_mode mode;
        int         left;
        int         phase;
        bit         held;
        mode  = SINK_OPEN;
        left  = 0;
        phase = 0;
        held  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !held) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (left == 0) begin
                    mode = t_sink_mode'($urandom_range(0, 3));
                    left = $urandom_range(20, 150);
                end
                left--;
                phase++;
                case (mode)
                    SINK_OPEN:  i_stall <= 1'b0;
                    SINK_LIGHT: i_stall <= ($urandom_range(0, 9) < 3);
                    SINK_HEAVY: i_stall <= ($urandom_range(0, 9) < 7);
                    default:    i_stall <= ((phase % 5) < 2);
                endcase
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(negedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle = 0;
            else idle++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int pick;
        int px;
        int py;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corners, fills, pixels off the left, right and top edges, a shifted
        // image that straddles the top and right edges, degenerate and tall images.
        read_beat(0, 0);
        send_beat(REQ_FILL, 0, 0, 0, 0, 8'hA5, 1'b1);
        read_beat(-256, -64);
        read_beat(127, 56);
        send_beat(REQ_FILL, 0, 0, 0, 0, 8'h00, 1'b1);
        send_beat(REQ_PIXEL, 0, 0, 0, 0, 8'h00, 1'b1);
        send_beat(REQ_PIXEL, 127, 63, 0, 0, 8'h00, 1'b1);
        send_beat(REQ_PIXEL, 255, -1, 0, 0, 8'h00, 1'b1);
        send_beat(REQ_PIXEL, -256, -128, 0, 0, 8'h00, 1'b1);
        read_beat(0, 0);
        read_beat(127, 63);
        send_beat(REQ_IMG_BEGIN, 126, -3, 3, 9, 8'h00, 1'b1);
        send_beat(REQ_IMG_BYTE, 0, 0, 0, 0, 8'hFF, 1'b1);
        send_beat(REQ_IMG_BYTE, 0, 0, 0, 0, 8'h81, 1'b1);
        send_beat(REQ_IMG_BYTE, 0, 0, 0, 0, 8'h7E, 1'b1);
        send_beat(REQ_IMG_BYTE, 0, 0, 0, 0, 8'hFF, 1'b1);
        send_beat(REQ_IMG_BYTE, 0, 0, 0, 0, 8'h00, 1'b1);
        send_beat(REQ_IMG_BYTE, 0, 0, 0, 0, 8'hC3, 1'b1);
        send_beat(REQ_IMG_BYTE, 0, 0, 0, 0, 8'hAA, 1'b0);
        read_beat(126, 0);
        read_beat(127, 8);
        send_beat(REQ_IMG_BEGIN, 0, 0, 0, 5, 8'h00, 1'b1);
        send_beat(REQ_IMG_BEGIN, 0, 0, 128, 0, 8'h00, 1'b1);
        send_beat(REQ_IMG_BYTE, 0, 0, 0, 0, 8'h55, 1'b0);
        send_beat(REQ_IMG_BEGIN, 250, 127, 255, 127, 8'h00, 1'b1);
        for (int k = 5; k < 8; k++) begin
            send_beat(REQ_W'(k), $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
        end

        // Random traffic, mostly complete images with reads in between.
        while (counted_items < ITEM_TARGET) begin
            if (!hold_go && counted_items >= HOLD_AT) hold_go <= 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                draw_image();
            end else if (pick < 63) begin
                repeat ($urandom_range(1, 6)) begin
                    px = rand_col();
                    py = rand_row();
                    send_beat(REQ_PIXEL, px, py, $urandom, $urandom, $urandom, 1'b1);
                    if ($urandom_range(0, 1) == 0) read_beat(px, py);
                end
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 8)) read_beat(rand_col(), rand_row());
            end else if (pick < 92) begin
                send_beat(REQ_FILL, $urandom, $urandom, $urandom, $urandom,
                          ($urandom_range(0, 2) == 0) ? $urandom : 0, 1'b1);
            end else begin
                // Noise: unknown codes, stray image bytes, arbitrary begins.
                case ($urandom_range(0, 2))
                    0: send_beat(REQ_W'($urandom_range(5, 7)), $urandom, $urandom,
                                 $urandom, $urandom, $urandom, 1'b0);
                    1: send_beat(REQ_IMG_BYTE, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, 1'b0);
                    default: send_beat(REQ_IMG_BEGIN, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, 1'b1);
                endcase
            end
        end
        i_valid <= 1'b0;

        // Drain the outstanding reads, then let a trailing fill finish.
        @(negedge i_clk);
        while (pending_reads != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d drawing requests: %0d fills, %0d pixels, %0d image bytes, %0d reads.",
                 counted_items, fills_sent, pixels_sent, img_beats, reads_sent);
        $display("Checked %0d read-back bytes, with bursty requests and one long result stall.",
                 reads_checked);
        if (fail_count == 0 && pending_reads == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule : tb_top

### files.f
rtl/pfb_pkg.sv
rtl/page_framebuffer_blit_engine.sv
rtl/pfb_checker.sv
tb/pfb_port_checker.sv
tb/tb_top.sv
